// ===== design/npp_pkg.sv =====
// ----------------------------------------------------------------------------
// npp_pkg
// Shared constants and helpers of the nearest-palette 4bpp packer.
// ----------------------------------------------------------------------------
package npp_pkg;

  localparam int unsigned PaletteEntries = 16;
  localparam int unsigned MaxWidth       = 4096;
  localparam int unsigned RowWidthW      = 13;
  localparam int unsigned ColorW         = 24;
  localparam int unsigned IndexW         = 4;
  localparam int unsigned DistW          = 18;

  localparam logic OpPalette = 1'b0;
  localparam logic OpPixel   = 1'b1;

  localparam logic [RowWidthW-1:0] RowWidthReset = 13'd1;
  localparam logic [1:0]           AddrRowWidth  = 2'd0;

  function automatic logic [ColorW-1:0] grey_default(input logic [IndexW-1:0] idx);
    logic [ColorW-1:0] c;
    unique case (idx)
      4'd4:    c = 24'h010101;
      4'd11:   c = 24'h6E6E6E;
      4'd12:   c = 24'h959595;
      4'd13:   c = 24'hB4B4B4;
      4'd14:   c = 24'hCFCFCF;
      4'd15:   c = 24'hFFFFFF;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic start;
    logic load_pal;
  } npp_cmd_t;

  typedef struct packed {
    logic                  done;
    logic [IndexW-1:0]     best;
  } npp_sts_t;

endpackage

// ===== design/nearest_palette_4bpp_packer.sv =====
// Flow: an accepted pixel is searched one palette entry per cycle, then its
// packed word and any padding words are emitted, each held by output stalls.
// A new pixel or palette write is taken only while idle with no word pending.
// Reset: row position cleared, row_width = 1, palette reads as the default grey
// table until entries are rewritten.
// ----------------------------------------------------------------------------
// nearest_palette_4bpp_packer
// Nearest-color 16-entry palette quantizer with 4bpp row packing and padding.
// ----------------------------------------------------------------------------
module nearest_palette_4bpp_packer #(
  parameter int unsigned PALETTE_ENTRIES = npp_pkg::PaletteEntries,
  parameter int unsigned MAX_WIDTH       = npp_pkg::MaxWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entry_index, entry_color, red, green, blue (bit 0 up)
  input  logic [55:0] s_axis_tdata,
  // op
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // packed_byte
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);

  logic [npp_pkg::RowWidthW-1:0] row_width_q;
  npp_pkg::npp_cmd_t             cmd;
  npp_pkg::npp_sts_t             sts;

  assign pready = 1'b1;
  assign prdata = (paddr == npp_pkg::AddrRowWidth) ? 32'(row_width_q) : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= npp_pkg::RowWidthReset;
    end else if (psel && penable && pwrite && paddr == npp_pkg::AddrRowWidth) begin
      row_width_q <= pwdata[npp_pkg::RowWidthW-1:0];
    end
  end

  npp_search #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_search (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .wr_index_i (s_axis_tdata[3:0]),
    .wr_color_i (s_axis_tdata[27:4]),
    .red_i      (s_axis_tdata[35:28]),
    .green_i    (s_axis_tdata[43:36]),
    .blue_i     (s_axis_tdata[51:44]),
    .sts_o      (sts)
  );

  npp_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .row_width_i (row_width_q),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while word pending");
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.start && cmd.load_pal)) else $error("start and palette load together");
  a_done_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.done |-> !s_axis_tready) else $error("search done while idle");
`endif

endmodule

// ===== design/npp_search.sv =====
// ----------------------------------------------------------------------------
// npp_search
// Palette store and iterative nearest-entry search, one entry per cycle.
// ----------------------------------------------------------------------------
module npp_search #(
  parameter int unsigned PALETTE_ENTRIES = npp_pkg::PaletteEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  npp_pkg::npp_cmd_t             cmd_i,
  input  logic [npp_pkg::IndexW-1:0]    wr_index_i,
  input  logic [npp_pkg::ColorW-1:0]    wr_color_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  output npp_pkg::npp_sts_t             sts_o
);

  localparam int unsigned N = 16;

  logic [N-1:0]                 valid_q;
  logic [npp_pkg::ColorW-1:0]   pal_q [N];
  logic [7:0]                   r_q, g_q, b_q;
  logic [npp_pkg::IndexW-1:0]   cnt_q;
  logic                         busy_q;
  logic [npp_pkg::DistW-1:0]    best_dist_q;
  logic [npp_pkg::IndexW-1:0]   best_q;
  logic                         done_q;
  logic [npp_pkg::ColorW-1:0]   c;
  logic [8:0]                   dr, dg, db;
  logic [7:0]                   ar, ag, ab;
  logic [npp_pkg::DistW-1:0]    cur_dist;
  logic                         last;

  always_comb begin
    c    = valid_q[cnt_q] ? pal_q[cnt_q] : npp_pkg::grey_default(cnt_q);
    dr   = {1'b0, r_q} - {1'b0, c[23:16]};
    dg   = {1'b0, g_q} - {1'b0, c[15:8]};
    db   = {1'b0, b_q} - {1'b0, c[7:0]};
    ar   = dr[8] ? 8'(-dr) : dr[7:0];
    ag   = dg[8] ? 8'(-dg) : dg[7:0];
    ab   = db[8] ? 8'(-db) : db[7:0];
    cur_dist = npp_pkg::DistW'(16'(ar * ar)) + npp_pkg::DistW'(16'(ag * ag))
             + npp_pkg::DistW'(16'(ab * ab));
    last = (cnt_q == npp_pkg::IndexW'(PALETTE_ENTRIES - 1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pal) begin
      pal_q[wr_index_i] <= wr_color_i;
    end
    if (cmd_i.start) begin
      r_q <= red_i;
      g_q <= green_i;
      b_q <= blue_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      best_dist_q <= '1;
      best_q      <= '0;
      done_q      <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.load_pal) begin
        valid_q[wr_index_i] <= 1'b1;
      end
      if (cmd_i.start) begin
        busy_q      <= 1'b1;
        cnt_q       <= '0;
        best_dist_q <= '1;
        best_q      <= '0;
      end else if (busy_q) begin
        if (cnt_q == '0 || cur_dist < best_dist_q) begin
          best_dist_q <= cur_dist;
          best_q      <= cnt_q;
        end
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.best = best_q;

endmodule

// ===== design/npp_ctrl.sv =====
// ----------------------------------------------------------------------------
// npp_ctrl
// Controller: input handshake, row tracking, byte packing and padding.
// ----------------------------------------------------------------------------
module npp_ctrl #(
  parameter int unsigned MAX_WIDTH = npp_pkg::MaxWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic [npp_pkg::RowWidthW-1:0]  row_width_i,
  output npp_pkg::npp_cmd_t              cmd_o,
  input  npp_pkg::npp_sts_t              sts_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_byte_o,
  output logic                           out_last_o
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH) + 1;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StEmit
  } state_e;

  state_e             state_q;
  logic [ColW-1:0]    col_q;
  logic [3:0]         held_q;
  logic [1:0]         phase_q;
  logic [2:0]         left_q;
  logic [7:0]         byte_q;
  logic               last_q;
  logic               ov_q;
  logic [ColW-1:0]    w;
  logic               eor;
  logic               emit;
  logic [1:0]         ph1;
  logic [1:0]         pads;
  logic [2:0]         total;
  logic [7:0]         first;

  always_comb begin
    priority if (row_width_i == '0) begin
      w = ColW'(1);
    end else if (32'(row_width_i) > MAX_WIDTH) begin
      w = ColW'(MAX_WIDTH);
    end else begin
      w = ColW'(row_width_i);
    end
    eor   = (32'(col_q) + 1 >= 32'(w));
    emit  = col_q[0] || eor;
    ph1   = emit ? phase_q + 2'd1 : phase_q;
    pads  = eor ? 2'(3'd4 - {1'b0, ph1}) : 2'd0;
    total = {2'b0, emit} + {1'b0, pads};
    first = col_q[0] ? {held_q, sts_i.best} : (emit ? {sts_i.best, 4'h0} : 8'h00);
  end

  assign in_ready_o = (state_q == StIdle) && !ov_q;
  assign cmd_o.load_pal = in_valid_i && in_ready_o && (op_i == npp_pkg::OpPalette);
  assign cmd_o.start    = in_valid_i && in_ready_o && (op_i == npp_pkg::OpPixel);
  assign out_valid_o = ov_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      col_q   <= '0;
      held_q  <= '0;
      phase_q <= '0;
      left_q  <= '0;
      byte_q  <= '0;
      last_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (cmd_o.start) begin
            state_q <= StSearch;
          end
        end
        StSearch: begin
          if (sts_i.done) begin
            if (eor) begin
              col_q   <= '0;
              held_q  <= '0;
              phase_q <= '0;
            end else begin
              col_q   <= col_q + 1'b1;
              phase_q <= ph1;
              if (!col_q[0]) begin
                held_q <= sts_i.best;
              end
            end
            if (total == 3'd0) begin
              state_q <= StIdle;
            end else begin
              byte_q  <= first;
              last_q  <= (total == 3'd1) && eor;
              ov_q    <= 1'b1;
              left_q  <= total - 3'd1;
              state_q <= StEmit;
            end
          end
        end
        StEmit: begin
          if (!ov_q || out_ready_i) begin
            if (left_q == 3'd0) begin
              ov_q    <= 1'b0;
              state_q <= StIdle;
            end else begin
              byte_q <= 8'h00;
              last_q <= (left_q == 3'd1);
              ov_q   <= 1'b1;
              left_q <= left_q - 3'd1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
